// ----- hdl/emdc_pkg.sv -----
`timescale 1ns / 1ps
package emdc_pkg;

  localparam int VEL_W = 16;
  localparam int POS_W = 16;
  localparam int DIFF_W = 17;        // difference of two 16-bit values
  localparam int SQ_W = 34;          // square of a 17-bit signed value
  localparam int PV_W = 33;          // scaled centre line, < 2^31 in magnitude on a hit
  localparam int WV_W = 34;          // scaled velocity difference through both rotations
  localparam int LIM_W = 15;         // (2r+1)*64
  localparam int PROD_W = 64;
  localparam int FRAC_SH = 42;
  localparam int R_W = PROD_W - FRAC_SH;
  localparam int SUM_W = R_W + 2;
  localparam logic [7:0] RADIUS_RESET = 8'd10;

  typedef logic signed [VEL_W-1:0] vel_t;

  // one classified transaction between front and back
  typedef struct packed {
    logic hit;
    vel_t v1x;
    vel_t v1y;
    vel_t v2x;
    vel_t v2y;
    logic signed [PV_W-1:0] px;
    logic signed [PV_W-1:0] py;
    logic signed [WV_W-1:0] wx;
    logic signed [WV_W-1:0] wy;
  } item_t;

  // 1/K^2 in Q30 for the given number of micro-rotations
  function automatic longint gain_q30(input int steps);
    longint g;
    longint d;
    longint q;
    longint rem;
    g = longint'(1) << 30;
    for (int i = 0; i < steps; i++) begin
      d = (longint'(1) << (2 * i)) + 1;
      // floor(g / d) by shift and subtract
      q = 0;
      rem = 0;
      for (int b = 62; b >= 0; b--) begin
        rem = (rem << 1) | ((g >> b) & longint'(1));
        q = q << 1;
        if (rem >= d) begin
          rem = rem - d;
          q = q | longint'(1);
        end
      end
      g = g - q;
    end
    return g;
  endfunction

endpackage

// ----- hdl/emdc_front.sv -----
`timescale 1ns / 1ps
module emdc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_take,
  input  logic [7:0]                   radius,
  input  logic [emdc_pkg::POS_W-1:0]   first_x,
  input  logic [emdc_pkg::POS_W-1:0]   first_y,
  input  logic [emdc_pkg::POS_W-1:0]   second_x,
  input  logic [emdc_pkg::POS_W-1:0]   second_y,
  input  emdc_pkg::vel_t               first_vel_x,
  input  emdc_pkg::vel_t               first_vel_y,
  input  emdc_pkg::vel_t               second_vel_x,
  input  emdc_pkg::vel_t               second_vel_y,
  output logic                         item_valid,
  output emdc_pkg::item_t              item
);

  localparam int DW = emdc_pkg::DIFF_W;
  localparam int SW = emdc_pkg::SQ_W;
  localparam int LW = emdc_pkg::LIM_W;

  // stage 1: differences and threshold
  logic v1;
  logic signed [DW-1:0] dx1, dy1, wdx1, wdy1;
  logic [LW-1:0] lim1;
  emdc_pkg::vel_t a1x, a1y, b1x, b1y;

  // stage 2: squares and centre-line setup
  logic v2;
  logic [SW-1:0] dxsq2, dysq2, limsq2;
  logic signed [emdc_pkg::PV_W-1:0] px2, py2;
  logic signed [DW-1:0] wdx2, wdy2;
  emdc_pkg::vel_t a2x, a2y, b2x, b2y;

  logic signed [DW-1:0] dxa, dya;
  logic [SW:0] dist_sq;

  always_comb begin
    dxa = dx1[DW-1] ? -dx1 : dx1;
    dya = dx1[DW-1] ? -dy1 : dy1;
    dist_sq = {1'b0, dxsq2} + {1'b0, dysq2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      item_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_take;
      v2 <= v1;
      item_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= $signed({1'b0, second_x}) - $signed({1'b0, first_x});
      dy1 <= $signed({1'b0, second_y}) - $signed({1'b0, first_y});
      wdx1 <= DW'(second_vel_x) - DW'(first_vel_x);
      wdy1 <= DW'(second_vel_y) - DW'(first_vel_y);
      lim1 <= {radius, 1'b1, 6'b0};
      a1x <= first_vel_x;
      a1y <= first_vel_y;
      b1x <= second_vel_x;
      b1y <= second_vel_y;

      dxsq2 <= SW'(dx1 * dx1);
      dysq2 <= SW'(dy1 * dy1);
      limsq2 <= SW'({{(SW-LW){1'b0}}, lim1} * {{(SW-LW){1'b0}}, lim1});
      if (dx1 == '0) begin
        // vertical line, coincident centres included
        px2 <= '0;
        py2 <= emdc_pkg::PV_W'(64'sd1 << 30);
      end else begin
        px2 <= emdc_pkg::PV_W'(dxa) <<< 14;
        py2 <= emdc_pkg::PV_W'(dya) <<< 14;
      end
      wdx2 <= wdx1;
      wdy2 <= wdy1;
      a2x <= a1x;
      a2y <= a1y;
      b2x <= b1x;
      b2y <= b1y;

      item.hit <= dist_sq <= {1'b0, limsq2};
      item.px <= px2;
      item.py <= py2;
      item.wx <= emdc_pkg::WV_W'(wdx2) <<< 12;
      item.wy <= emdc_pkg::WV_W'(wdy2) <<< 12;
      item.v1x <= a2x;
      item.v1y <= a2y;
      item.v2x <= b2x;
      item.v2y <= b2y;
    end
  end

endmodule

// ----- hdl/emdc_fifo.sv -----
`timescale 1ns / 1ps
module emdc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  emdc_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output emdc_pkg::item_t head
);

  localparam int DEPTH = 4;
  localparam int AW = $clog2(DEPTH);

  emdc_pkg::item_t mem [0:DEPTH-1];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count;

  assign full = count == (AW+1)'(DEPTH);
  assign empty = count == '0;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

// ----- hdl/emdc_back.sv -----
`timescale 1ns / 1ps
module emdc_back #(
  parameter int ROTATE_STEPS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            src_valid,
  input  emdc_pkg::item_t src_item,
  output logic            res_valid,
  output logic            res_hit,
  output emdc_pkg::vel_t  res_v1x,
  output emdc_pkg::vel_t  res_v1y,
  output emdc_pkg::vel_t  res_v2x,
  output emdc_pkg::vel_t  res_v2y
);

  localparam int N = ROTATE_STEPS;
  localparam int NS = 2 * N;
  localparam int PW = emdc_pkg::PV_W;
  localparam int WW = emdc_pkg::WV_W;
  localparam int RW = emdc_pkg::R_W;
  localparam int SUMW = emdc_pkg::SUM_W;
  localparam logic signed [31:0] GAIN = 32'(emdc_pkg::gain_q30(ROTATE_STEPS));
  localparam logic signed [emdc_pkg::PROD_W-1:0] ROUND = 64'sd1 <<< (emdc_pkg::FRAC_SH - 1);

  emdc_pkg::item_t stg [0:NS];
  logic [N-1:0] sg [0:NS];
  logic vld [0:NS];

  assign stg[0] = src_item;
  assign sg[0] = '0;
  assign vld[0] = src_valid;

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_rot
      localparam int SH = (k < N) ? k : (NS - 1 - k);
      emdc_pkg::item_t nxt;
      logic [N-1:0] sg_nxt;
      logic signed [WW-1:0] wy_in;
      logic neg;

      always_comb begin
        nxt = stg[k];
        sg_nxt = sg[k];
        // the back rotation starts from (a, 0)
        wy_in = (k == N) ? '0 : stg[k].wy;
        if (k < N) begin
          neg = stg[k].py[PW-1];
          sg_nxt[SH] = neg;
          if (neg) begin
            nxt.px = stg[k].px - (stg[k].py >>> SH);
            nxt.py = stg[k].py + (stg[k].px >>> SH);
          end else begin
            nxt.px = stg[k].px + (stg[k].py >>> SH);
            nxt.py = stg[k].py - (stg[k].px >>> SH);
          end
        end else begin
          // opposite direction of the recorded decision
          neg = !sg[k][SH];
        end
        if (neg) begin
          nxt.wx = stg[k].wx - (wy_in >>> SH);
          nxt.wy = wy_in + (stg[k].wx >>> SH);
        end else begin
          nxt.wx = stg[k].wx + (wy_in >>> SH);
          nxt.wy = wy_in - (stg[k].wx >>> SH);
        end
      end

      always_ff @(posedge clk) begin
        if (rst) vld[k+1] <= 1'b0;
        else if (en) vld[k+1] <= vld[k];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          stg[k+1] <= nxt;
          sg[k+1] <= sg_nxt;
        end
      end
    end
  endgenerate

  // gain correction
  logic mvld;
  logic signed [emdc_pkg::PROD_W-1:0] prx, pry;
  emdc_pkg::item_t mit;

  logic signed [emdc_pkg::PROD_W-1:0] sx, sy;
  logic signed [RW-1:0] rx, ry;
  logic signed [SUMW-1:0] n1x, n1y, n2x, n2y;

  function automatic emdc_pkg::vel_t sat(input logic signed [SUMW-1:0] v);
    if (v > SUMW'(32767)) return 16'sh7fff;
    else if (v < -SUMW'(32768)) return 16'sh8000;
    else return v[15:0];
  endfunction

  always_comb begin
    sx = prx + ROUND;
    sy = pry + ROUND;
    rx = sx[emdc_pkg::PROD_W-1:emdc_pkg::FRAC_SH];
    ry = sy[emdc_pkg::PROD_W-1:emdc_pkg::FRAC_SH];
    n1x = SUMW'(mit.v1x) + SUMW'(rx);
    n1y = SUMW'(mit.v1y) + SUMW'(ry);
    n2x = SUMW'(mit.v2x) - SUMW'(rx);
    n2y = SUMW'(mit.v2y) - SUMW'(ry);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mvld <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      mvld <= vld[NS];
      res_valid <= mvld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mit <= stg[NS];
      prx <= emdc_pkg::PROD_W'($signed(stg[NS].wx[31:0]) * GAIN);
      pry <= emdc_pkg::PROD_W'($signed(stg[NS].wy[31:0]) * GAIN);
      res_hit <= mit.hit;
      if (mit.hit) begin
        res_v1x <= sat(n1x);
        res_v1y <= sat(n1y);
        res_v2x <= sat(n2x);
        res_v2y <= sat(n2y);
      end else begin
        res_v1x <= mit.v1x;
        res_v1y <= mit.v1y;
        res_v2x <= mit.v2x;
        res_v2y <= mit.v2y;
      end
    end
  end

endmodule

// ----- hdl/equal_mass_disc_collision.sv -----
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while out_ready is held high; each micro-rotation is its own pipeline stage.
// A 4-entry queue sits between the classify front end and the rotation back end.
// Reset (rst, synchronous) empties the pipeline and queue and sets ball_radius to 10.
module equal_mass_disc_collision #(
  parameter int ROTATE_STEPS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [7:0]                 ball_radius,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [emdc_pkg::POS_W-1:0] first_x,
  input  logic [emdc_pkg::POS_W-1:0] first_y,
  input  logic [emdc_pkg::POS_W-1:0] second_x,
  input  logic [emdc_pkg::POS_W-1:0] second_y,
  input  emdc_pkg::vel_t             first_vel_x,
  input  emdc_pkg::vel_t             first_vel_y,
  input  emdc_pkg::vel_t             second_vel_x,
  input  emdc_pkg::vel_t             second_vel_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       hit,
  output emdc_pkg::vel_t             first_new_vx,
  output emdc_pkg::vel_t             first_new_vy,
  output emdc_pkg::vel_t             second_new_vx,
  output emdc_pkg::vel_t             second_new_vy
);

  logic [7:0] radius;
  logic front_en, back_en;
  logic f_valid, q_full, q_empty, q_pop;
  emdc_pkg::item_t f_item, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) radius <= emdc_pkg::RADIUS_RESET;
    else if (cfg_valid) radius <= ball_radius;
  end

  assign front_en = !f_valid || !q_full;
  assign in_ready = front_en;
  assign back_en = !out_valid || out_ready;
  assign q_pop = back_en && !q_empty;

  emdc_front u_front (
    .clk(clk),
    .rst(rst),
    .en(front_en),
    .in_take(in_valid),
    .radius(radius),
    .first_x(first_x),
    .first_y(first_y),
    .second_x(second_x),
    .second_y(second_y),
    .first_vel_x(first_vel_x),
    .first_vel_y(first_vel_y),
    .second_vel_x(second_vel_x),
    .second_vel_y(second_vel_y),
    .item_valid(f_valid),
    .item(f_item)
  );

  emdc_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(f_valid && !q_full),
    .push_item(f_item),
    .pop(q_pop),
    .full(q_full),
    .empty(q_empty),
    .head(q_head)
  );

  emdc_back #(
    .ROTATE_STEPS(ROTATE_STEPS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .en(back_en),
    .src_valid(!q_empty),
    .src_item(q_head),
    .res_valid(out_valid),
    .res_hit(hit),
    .res_v1x(first_new_vx),
    .res_v1y(first_new_vy),
    .res_v2x(second_new_vx),
    .res_v2y(second_new_vy)
  );

endmodule

// ----- tb/sv/tb_equal_mass_disc_collision.sv -----
`timescale 1ns / 1ps
module tb_equal_mass_disc_collision;

  localparam int STEPS = 16;
  localparam int LATENCY = 2 * STEPS + 5;
  localparam int N_RANDOM = 700;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [15:0] x1, y1, x2, y2;
    logic signed [15:0] v1x, v1y, v2x, v2y;
  } pair_t;

  typedef struct {
    logic hit;
    logic signed [15:0] v1x, v1y, v2x, v2y;
  } bounce_t;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // predicts the outgoing velocities of one disc pair
  function automatic bounce_t predict_bounce(pair_t p, logic [7:0] radius);
    bounce_t b;
    longint dx, dy, lim, px, py, wx, wy, g, t, rx, ry;
    int dir[STEPS];
    int s;
    dx = longint'(p.x2) - longint'(p.x1);
    dy = longint'(p.y2) - longint'(p.y1);
    lim = (2 * longint'(radius) + 1) * 64;
    b.hit = (dx * dx + dy * dy) <= lim * lim;
    if (!b.hit) begin
      b.v1x = p.v1x; b.v1y = p.v1y; b.v2x = p.v2x; b.v2y = p.v2y;
      return b;
    end
    if (dx == 0) begin
      px = 0; py = longint'(1) << 30;
    end else begin
      if (dx < 0) begin
        dx = -dx; dy = -dy;
      end
      px = dx * 16384; py = dy * 16384;
    end
    wx = (longint'(p.v2x) - longint'(p.v1x)) * 4096;
    wy = (longint'(p.v2y) - longint'(p.v1y)) * 4096;
    g = longint'(1) << 30;
    for (int i = 0; i < STEPS; i++) begin
      s = (py < 0) ? 1 : -1;
      dir[i] = s;
      t = px - s * floor_shift(py, i);
      py = py + s * floor_shift(px, i);
      px = t;
      t = wx - s * floor_shift(wy, i);
      wy = wy + s * floor_shift(wx, i);
      wx = t;
      g = g - g / ((longint'(1) << (2 * i)) + 1);
    end
    wy = 0;
    for (int i = STEPS - 1; i >= 0; i--) begin
      s = -dir[i];
      t = wx - s * floor_shift(wy, i);
      wy = wy + s * floor_shift(wx, i);
      wx = t;
    end
    rx = floor_shift(wx * g + (longint'(1) << 41), 42);
    ry = floor_shift(wy * g + (longint'(1) << 41), 42);
    b.v1x = 16'(clamp16(longint'(p.v1x) + rx));
    b.v1y = 16'(clamp16(longint'(p.v1y) + ry));
    b.v2x = 16'(clamp16(longint'(p.v2x) - rx));
    b.v2y = 16'(clamp16(longint'(p.v2y) - ry));
    return b;
  endfunction

  class bounce_scoreboard;
    bounce_t pending[$];
    int errors;
    int checked;
    int hits;

    function void note_pair(pair_t p, logic [7:0] radius);
      pending.push_back(predict_bounce(p, radius));
    endfunction

    function void check_field(string name, logic signed [15:0] e, logic signed [15:0] a);
      if (e !== a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(bounce_t got);
      bounce_t e;
      if (pending.size() == 0) begin
        $error("result with no pending transaction");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.hit) hits++;
      if (e.hit !== got.hit) begin
        $error("hit: expected %0d, got %0d", e.hit, got.hit);
        errors++;
      end
      check_field("first_new_vx", e.v1x, got.v1x);
      check_field("first_new_vy", e.v1y, got.v1y);
      check_field("second_new_vx", e.v2x, got.v2x);
      check_field("second_new_vy", e.v2y, got.v2y);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [7:0] ball_radius = 8'd0;
  logic in_valid = 0;
  logic in_ready;
  logic [15:0] first_x = 0, first_y = 0, second_x = 0, second_y = 0;
  logic signed [15:0] first_vel_x = 0, first_vel_y = 0, second_vel_x = 0, second_vel_y = 0;
  logic out_valid;
  logic out_ready = 0;
  logic hit;
  logic signed [15:0] first_new_vx, first_new_vy, second_new_vx, second_new_vy;

  bounce_scoreboard sb = new();
  logic [7:0] radius_now = emdc_pkg::RADIUS_RESET;
  bit long_stall = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int sent = 0;

  always #5 clk = ~clk;

  equal_mass_disc_collision #(.ROTATE_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .ball_radius(ball_radius),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
    .first_vel_x(first_vel_x), .first_vel_y(first_vel_y),
    .second_vel_x(second_vel_x), .second_vel_y(second_vel_y),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
    .first_new_vx(first_new_vx), .first_new_vy(first_new_vy),
    .second_new_vx(second_new_vx), .second_new_vy(second_new_vy)
  );

  // result side: check and stall pattern
  always @(posedge clk) begin
    bounce_t got;
    if (!rst && out_valid && out_ready) begin
      got.hit = hit;
      got.v1x = first_new_vx; got.v1y = first_new_vy;
      got.v2x = second_new_vx; got.v2y = second_new_vy;
      sb.check_result(got);
    end
    if (long_stall) out_ready <= 1'b0;
    else if (sb.checked % 200 < 60) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // watchdog: cycles with no transaction at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_radius(logic [7:0] r);
    @(posedge clk);
    cfg_valid <= 1'b1;
    ball_radius <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radius_now = r;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // offers one pair; random gaps between bursts when gaps is set
  task automatic send_pair(pair_t p, bit gaps);
    if (gaps) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 1)) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    first_x <= p.x1; first_y <= p.y1; second_x <= p.x2; second_y <= p.y2;
    first_vel_x <= p.v1x; first_vel_y <= p.v1y;
    second_vel_x <= p.v2x; second_vel_y <= p.v2y;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(p, radius_now);
    sent++;
  endtask

  function automatic logic [15:0] rand_vel();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 255) - 128);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly pairs near contact distance
  function automatic pair_t rand_pair(logic [7:0] radius);
    pair_t p;
    int reach, ox, oy;
    p.x1 = 16'($urandom); p.y1 = 16'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      p.x2 = 16'($urandom); p.y2 = 16'($urandom);
    end else begin
      reach = (2 * radius + 2) * 64;
      ox = $urandom_range(0, 2 * reach) - reach;
      oy = $urandom_range(0, 2 * reach) - reach;
      if ($urandom_range(0, 9) == 0) ox = 0;
      p.x2 = 16'(int'(p.x1) + ox);
      p.y2 = 16'(int'(p.y1) + oy);
    end
    p.v1x = rand_vel(); p.v1y = rand_vel(); p.v2x = rand_vel(); p.v2y = rand_vel();
    return p;
  endfunction

  function automatic pair_t make_pair(int x1, int y1, int x2, int y2,
                                      int a, int b, int c, int d);
    pair_t p;
    p.x1 = 16'(x1); p.y1 = 16'(y1); p.x2 = 16'(x2); p.y2 = 16'(y2);
    p.v1x = 16'(a); p.v1y = 16'(b); p.v2x = 16'(c); p.v2y = 16'(d);
    return p;
  endfunction

  initial begin
    logic [7:0] radii[5] = '{8'd1, 8'd255, 8'd0, 8'd37, 8'd10};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed, reset radius 10: threshold 21 px = 1344 in Q.6
    send_pair(make_pair(1000, 1000, 1000, 1000, 256, -256, -512, 512), 0);   // coincident
    send_pair(make_pair(1000, 1000, 1000, 2344, 0, 256, 0, -256), 0);       // vertical, at edge
    send_pair(make_pair(1000, 1000, 1000, 2345, 0, 256, 0, -256), 0);       // just outside
    send_pair(make_pair(1000, 1000, 2344, 1000, 256, 0, -256, 0), 0);       // horizontal edge
    send_pair(make_pair(2344, 1000, 1000, 1000, 256, 0, -256, 0), 0);       // dx < 0
    send_pair(make_pair(5000, 5000, 4100, 5900, 32767, -32768, -32768, 32767), 0);
    send_pair(make_pair(5000, 5000, 5900, 4100, -32768, 32767, 32767, -32768), 0);
    send_pair(make_pair(0, 0, 65535, 65535, 32767, 32767, -32768, -32768), 0);
    send_pair(make_pair(65535, 65535, 65535, 65535, -1, -1, 1, 1), 0);
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_pair(make_pair(100, 100, 500, 900, 16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC), 0);
    drain();

    foreach (radii[k]) begin
      write_radius(radii[k]);
      if (k == 2) begin
        send_pair(make_pair(3000, 3000, 3064, 3000, 256, 0, 0, 0), 0);  // 1 px at radius 0
        send_pair(make_pair(3000, 3000, 3065, 3000, 256, 0, 0, 0), 0);
      end
      if (k == 1) begin
        // hold the receiver off while pairs keep coming, so the block backs up
        fork
          begin
            long_stall = 1;
            repeat (300) @(posedge clk);
            long_stall = 0;
          end
          repeat (80) send_pair(rand_pair(radius_now), 0);
        join
        drain(); // sender pauses until all results are back
      end
      repeat (N_RANDOM / 5) send_pair(rand_pair(radius_now), 1);
      drain();
    end

    $display("checked %0d collision results (%0d hits) over %0d radius settings",
             sb.checked, sb.hits, 6);
    $display("pairs sent %0d, with directed edge, vertical and saturation cases", sent);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- equal_mass_disc_collision.f -----
hdl/emdc_pkg.sv
hdl/emdc_front.sv
hdl/emdc_fifo.sv
hdl/emdc_back.sv
hdl/equal_mass_disc_collision.sv
tb/sv/tb_equal_mass_disc_collision.sv
